@@ hdl/dem_hillshade_normal_map_defines.svh @@
// ----------------------------------------------------------------------------
// Hillshade normal map: assertion macros
// Used by the module that carries concurrent checks (dhnm_queue).
// ----------------------------------------------------------------------------
`ifndef DEM_HILLSHADE_NORMAL_MAP_DEFINES_SVH
`define DEM_HILLSHADE_NORMAL_MAP_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define DHNM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define DHNM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/dhnm_pkg.sv @@
// ----------------------------------------------------------------------------
// dhnm_pkg
// Constants, widths and the quad record shared by the hillshade modules.
// ----------------------------------------------------------------------------
package dhnm_pkg;

  localparam int GRID_POINTS = 1201;
  localparam int FRAC_BITS   = 14;

  localparam int ADDR_W   = $clog2(GRID_POINTS);
  localparam int COORD_W  = 12;
  localparam int HEIGHT_W = 16;
  localparam int CHAN_W   = 8;
  localparam int COLOR_W  = 3 * CHAN_W;
  localparam int SAMPLE_W = HEIGHT_W + COLOR_W;

  // vector magnitudes are scaled up until the largest reaches 2^NORM_TOP
  localparam int NORM_TOP = 24;
  localparam int MAG_W    = NORM_TOP + 1;
  localparam int SUM_W    = 2 * MAG_W + 2;
  localparam int ROOT_W   = SUM_W / 2;
  localparam int DEN_W    = ROOT_W;
  localparam int NUM_W    = MAG_W + FRAC_BITS;

  localparam int UNIT_W = FRAC_BITS + 1;  // 0 .. ONE
  localparam int N_W    = FRAC_BITS + 2;  // signed -ONE .. ONE
  localparam int V_W    = ((HEIGHT_W > N_W) ? HEIGHT_W : N_W) + 1;
  localparam int TM_W   = FRAC_BITS + 2;  // |nx - ny + nz| <= 3*ONE

  localparam logic [UNIT_W-1:0] ONE_Q = UNIT_W'(1) << FRAC_BITS;
  localparam int Z_SPACING   = 90;
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [HEIGHT_W-1:0] z00;
    logic [HEIGHT_W-1:0] z01;
    logic [HEIGHT_W-1:0] z10;
    logic [HEIGHT_W-1:0] z11;
    logic [COLOR_W-1:0]  base;
    logic [COORD_W-1:0]  row;
    logic [COORD_W-1:0]  col;
    logic                last;
  } quad_t;

endpackage

@@ hdl/dem_hillshade_normal_map.sv @@
// ----------------------------------------------------------------------------
// dem_hillshade_normal_map
// Hillshade / normal-map pixel kernel over a raster stream of elevations.
//
// Port group | Handshake              | Carries
// in_        | in_valid / in_stall    | height, base colour
// out_       | out_valid / out_stall  | pixel colour, row, column, last flag
// cfg_       | cfg_wr_en              | relief_mode (reset 1)
//
// Front: a sample is read from the line buffer when taken, then pushed to the
// queue; in_stall holds off the next sample until the push state is left.
// Back: one pixel at a time on the shared serial divider and square-root
// units (one bit per cycle, three normalizations plus the dot-product root).
// Reset is synchronous; the line buffer is not cleared, raster order fills it.
// out_stall holds the back; the front keeps taking samples until the
// two-entry quad queue is full.
// ----------------------------------------------------------------------------
module dem_hillshade_normal_map (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [dhnm_pkg::HEIGHT_W-1:0] in_height,
  input  logic [dhnm_pkg::CHAN_W-1:0]   in_base_red,
  input  logic [dhnm_pkg::CHAN_W-1:0]   in_base_green,
  input  logic [dhnm_pkg::CHAN_W-1:0]   in_base_blue,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [dhnm_pkg::CHAN_W-1:0]   out_pixel_red,
  output logic [dhnm_pkg::CHAN_W-1:0]   out_pixel_green,
  output logic [dhnm_pkg::CHAN_W-1:0]   out_pixel_blue,
  output logic [dhnm_pkg::COORD_W-1:0]  out_pixel_row,
  output logic [dhnm_pkg::COORD_W-1:0]  out_pixel_col,
  output logic                          out_last_pixel
);
  import dhnm_pkg::*;

  logic  relief_mode_r;
  logic  q_push;
  logic  q_pop;
  logic  q_full;
  logic  q_empty;
  quad_t q_in;
  quad_t q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) relief_mode_r <= 1'b1;
    else if (cfg_wr_en) relief_mode_r <= cfg_wr_data;
  end

  dhnm_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_height     (in_height),
    .in_base_red   (in_base_red),
    .in_base_green (in_base_green),
    .in_base_blue  (in_base_blue),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (q_in)
  );

  dhnm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  dhnm_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .relief_mode     (relief_mode_r),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_red   (out_pixel_red),
    .out_pixel_green (out_pixel_green),
    .out_pixel_blue  (out_pixel_blue),
    .out_pixel_row   (out_pixel_row),
    .out_pixel_col   (out_pixel_col),
    .out_last_pixel  (out_last_pixel)
  );

endmodule

@@ hdl/dhnm_front.sv @@
// ----------------------------------------------------------------------------
// dhnm_front
// Takes samples, keeps the row line buffer and the left and upper-left
// samples, and pushes one quad record per lower-right corner.
// ----------------------------------------------------------------------------
module dhnm_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [dhnm_pkg::HEIGHT_W-1:0]  in_height,
  input  logic [dhnm_pkg::CHAN_W-1:0]    in_base_red,
  input  logic [dhnm_pkg::CHAN_W-1:0]    in_base_green,
  input  logic [dhnm_pkg::CHAN_W-1:0]    in_base_blue,
  input  logic                           q_full,
  output logic                           q_push,
  output dhnm_pkg::quad_t                q_data
);
  import dhnm_pkg::*;

  localparam logic F_IDLE = 1'b0;
  localparam logic F_PUSH = 1'b1;

  logic                st_r;
  logic [ADDR_W-1:0]   col_r;
  logic [ADDR_W-1:0]   row_r;
  logic [SAMPLE_W-1:0] line_mem [GRID_POINTS];
  logic [SAMPLE_W-1:0] above_r;
  logic [SAMPLE_W-1:0] cur_r;
  logic [SAMPLE_W-1:0] left_r;
  logic [SAMPLE_W-1:0] ul_r;
  logic [SAMPLE_W-1:0] cur_in;
  logic                accept;
  logic                emit;
  logic                adv;
  logic                col_end;
  logic                row_end;

  assign cur_in   = {in_height, in_base_red, in_base_green, in_base_blue};
  assign in_stall = (st_r != F_IDLE);
  assign accept   = in_valid && (st_r == F_IDLE);
  assign emit     = (row_r != '0) && (col_r != '0);
  assign adv      = (st_r == F_PUSH) && (!emit || !q_full);
  assign q_push   = (st_r == F_PUSH) && emit && !q_full;
  assign col_end  = (col_r == ADDR_W'(GRID_POINTS - 1));
  assign row_end  = (row_r == ADDR_W'(GRID_POINTS - 1));

  // read-first line buffer: the old entry is the upper-right corner
  always_ff @(posedge clk) begin
    if (accept) begin
      line_mem[col_r] <= cur_in;
      above_r         <= line_mem[col_r];
      cur_r           <= cur_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= F_IDLE;
      col_r  <= '0;
      row_r  <= '0;
      left_r <= '0;
      ul_r   <= '0;
    end else begin
      unique case (st_r)
        F_IDLE: begin
          if (accept) st_r <= F_PUSH;
        end
        F_PUSH: begin
          if (adv) begin
            st_r   <= F_IDLE;
            ul_r   <= above_r;
            left_r <= cur_r;
            if (col_end) begin
              col_r <= '0;
              row_r <= row_end ? '0 : row_r + 1'b1;
            end else begin
              col_r <= col_r + 1'b1;
            end
          end
        end
        default: st_r <= F_IDLE;
      endcase
    end
  end

  always_comb begin
    q_data.z00  = ul_r[SAMPLE_W-1 -: HEIGHT_W];
    q_data.z01  = above_r[SAMPLE_W-1 -: HEIGHT_W];
    q_data.z10  = left_r[SAMPLE_W-1 -: HEIGHT_W];
    q_data.z11  = cur_r[SAMPLE_W-1 -: HEIGHT_W];
    q_data.base = ul_r[COLOR_W-1:0];
    q_data.row  = COORD_W'(GRID_POINTS - 1) - COORD_W'(row_r);
    q_data.col  = COORD_W'(col_r) - COORD_W'(1);
    q_data.last = row_end && col_end;
  end

endmodule

@@ hdl/dhnm_queue.sv @@
// ----------------------------------------------------------------------------
// dhnm_queue
// Short FIFO of quad records between the front and the shading engine.
// ----------------------------------------------------------------------------
`include "dem_hillshade_normal_map_defines.svh"

module dhnm_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  dhnm_pkg::quad_t push_data,
  input  logic            pop,
  output dhnm_pkg::quad_t head,
  output logic            full,
  output logic            empty
);
  import dhnm_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  quad_t            slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  `DHNM_ASSERT_NOW(a_no_overflow, push, !full || pop, "quad pushed into a full queue")
  `DHNM_ASSERT_NOW(a_no_underflow, pop, !empty, "quad popped from an empty queue")
  `DHNM_ASSERT_NEXT(a_count_up, rst_n && push && !pop, count_r == $past(count_r) + 1'b1, "queue count did not follow a push")

endmodule

@@ hdl/dhnm_isqrt.sv @@
// ----------------------------------------------------------------------------
// dhnm_isqrt
// Bit-pair integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module dhnm_isqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [dhnm_pkg::SUM_W-1:0]   radicand,
  output logic                         done,
  output logic [dhnm_pkg::ROOT_W-1:0]  root
);
  import dhnm_pkg::*;

  logic [SUM_W-1:0] x_r;
  logic [SUM_W-1:0] r_r;
  logic [SUM_W-1:0] b_r;
  logic             busy_r;
  logic             done_r;
  logic [SUM_W:0]   trial;

  assign trial = {1'b0, r_r} + {1'b0, b_r};
  assign done  = done_r;
  assign root  = r_r[ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (b_r == SUM_W'(1))) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= radicand;
      r_r <= '0;
      b_r <= SUM_W'(1) << (SUM_W - 2);
    end else if (busy_r) begin
      if ({1'b0, x_r} >= trial) begin
        x_r <= x_r - trial[SUM_W-1:0];
        r_r <= (r_r >> 1) + b_r;
      end else begin
        r_r <= r_r >> 1;
      end
      b_r <= b_r >> 2;
    end
  end

endmodule

@@ hdl/dhnm_div.sv @@
// ----------------------------------------------------------------------------
// dhnm_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dhnm_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [dhnm_pkg::NUM_W-1:0]  dividend,
  input  logic [dhnm_pkg::DEN_W-1:0]  divisor,
  output logic                        done,
  output logic [dhnm_pkg::NUM_W-1:0]  quotient
);
  import dhnm_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign trial    = {rem_r, num_r[NUM_W-1]};
  assign diff     = trial - {1'b0, den_r};
  assign ge       = (trial >= {1'b0, den_r});
  assign done     = done_r;
  assign quotient = num_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == CNT_W'(1))) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // dividend register shifts out at the top and collects quotient bits below
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      den_r <= divisor;
      rem_r <= '0;
      cnt_r <= CNT_W'(NUM_W);
    end else if (busy_r) begin
      rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      num_r <= {num_r[NUM_W-2:0], ge};
      cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

@@ hdl/dhnm_back.sv @@
// ----------------------------------------------------------------------------
// dhnm_back
// Shading engine: two triangle normals, their average, the light dot
// product and the relief or normal-map colour, on shared serial units.
// ----------------------------------------------------------------------------
module dhnm_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  dhnm_pkg::quad_t               q_head,
  output logic                          q_pop,
  input  logic                          relief_mode,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [dhnm_pkg::CHAN_W-1:0]   out_pixel_red,
  output logic [dhnm_pkg::CHAN_W-1:0]   out_pixel_green,
  output logic [dhnm_pkg::CHAN_W-1:0]   out_pixel_blue,
  output logic [dhnm_pkg::COORD_W-1:0]  out_pixel_row,
  output logic [dhnm_pkg::COORD_W-1:0]  out_pixel_col,
  output logic                          out_last_pixel
);
  import dhnm_pkg::*;

  localparam logic [3:0] B_IDLE = 4'd0;
  localparam logic [3:0] B_SCAN = 4'd1;
  localparam logic [3:0] B_SQ   = 4'd2;
  localparam logic [3:0] B_ACC  = 4'd3;
  localparam logic [3:0] B_RTGO = 4'd4;
  localparam logic [3:0] B_RTW  = 4'd5;
  localparam logic [3:0] B_DVGO = 4'd6;
  localparam logic [3:0] B_DVW  = 4'd7;
  localparam logic [3:0] B_NEXT = 4'd8;
  localparam logic [3:0] B_DOT  = 4'd9;
  localparam logic [3:0] B_TSQ  = 4'd10;
  localparam logic [3:0] B_MIX  = 4'd11;
  localparam logic [3:0] B_PROD = 4'd12;
  localparam logic [3:0] B_F    = 4'd13;
  localparam logic [3:0] B_CHAN = 4'd14;
  localparam logic [3:0] B_OUT  = 4'd15;

  // pass: which vector is being normalized, or the dot product
  localparam logic [1:0] P_A   = 2'd0;
  localparam logic [1:0] P_B   = 2'd1;
  localparam logic [1:0] P_S   = 2'd2;
  localparam logic [1:0] P_DOT = 2'd3;

  localparam logic [1:0] LAST_IDX = 2'd2;

  // ceil(2^33 / 3): x / 3 == (x * RECIP_3) >> 33 for any 32-bit x
  localparam logic [32:0] RECIP_3 = 33'h0_AAAA_AAAB;

  function automatic logic [CHAN_W-1:0] sat_chan(input logic [CHAN_W:0] v);
    sat_chan = v[CHAN_W] ? {CHAN_W{1'b1}} : v[CHAN_W-1:0];
  endfunction

  function automatic logic [CHAN_W-1:0] shade_chan(input logic [CHAN_W-1:0] b,
                                                   input logic [UNIT_W-1:0] f);
    logic [CHAN_W+UNIT_W-1:0] w;
    w = (CHAN_W+UNIT_W)'(b) * (CHAN_W+UNIT_W)'(f);
    shade_chan = sat_chan(w[FRAC_BITS +: CHAN_W+1]);
  endfunction

  // 255 * u / (2*ONE), with u = ONE + n
  function automatic logic [CHAN_W-1:0] norm_chan(input logic [N_W-1:0] u);
    logic [N_W+CHAN_W-1:0] w;
    w = {u, CHAN_W'(0)} - (N_W+CHAN_W)'(u);
    norm_chan = sat_chan(w[FRAC_BITS+1 +: CHAN_W+1]);
  endfunction

  logic [3:0]                st_r;
  logic [3:0]                st_nxt;
  logic [1:0]                pass_r;
  logic [1:0]                idx_r;
  quad_t                     quad_r;
  logic [MAG_W-1:0]          mag_r [3];
  logic [2:0]                sgn_r;
  logic [2*MAG_W-1:0]        sq_r;
  logic [SUM_W-1:0]          acc_r;
  logic [ROOT_W-1:0]         len_r;
  logic signed [N_W-1:0]     na_r [3];
  logic signed [N_W-1:0]     nb_r [3];
  logic signed [N_W-1:0]     n_r  [3];
  logic                      tneg_r;
  logic [TM_W-1:0]           tm_r;
  logic [2*TM_W-1:0]         tsq_r;
  logic [2*TM_W-1:0]         tq_r;
  logic [UNIT_W-1:0]         dm_r;
  logic [UNIT_W-1:0]         mix_r;
  logic [UNIT_W-1:0]         prod_r;
  logic [UNIT_W-1:0]         f_r;
  logic [CHAN_W-1:0]         red_r;
  logic [CHAN_W-1:0]         green_r;
  logic [CHAN_W-1:0]         blue_r;

  logic signed [V_W-1:0]     ld_v [3];
  logic [MAG_W-1:0]          m_max;
  logic                      scan_done;
  logic                      scan_small;
  logic                      rt_start;
  logic [SUM_W-1:0]          rt_x;
  logic                      rt_done;
  logic [ROOT_W-1:0]         rt_root;
  logic                      dv_start;
  logic [NUM_W-1:0]          dv_num;
  logic [DEN_W-1:0]          dv_den;
  logic                      dv_done;
  logic [NUM_W-1:0]          dv_quot;
  logic [UNIT_W-1:0]         q_sat;
  logic signed [N_W-1:0]     comp;
  logic signed [N_W+1:0]     t_sum;
  logic [UNIT_W+1:0]         mix_sum;
  logic [2*UNIT_W-1:0]       prod_full;
  logic signed [UNIT_W+1:0]  f_sum;
  logic [2*TM_W+32:0]        tq_prod;

  dhnm_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rt_start),
    .radicand (rt_x),
    .done     (rt_done),
    .root     (rt_root)
  );

  dhnm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dv_start),
    .dividend (dv_num),
    .divisor  (dv_den),
    .done     (dv_done),
    .quotient (dv_quot)
  );

  // vector to load: edges of triangle A from the queue head, triangle B
  // from the held quad, or the sum of the two unit normals
  always_comb begin
    if (st_r == B_IDLE) begin
      ld_v[0] = $signed(V_W'(q_head.z00)) - $signed(V_W'(q_head.z10));
      ld_v[1] = $signed(V_W'(q_head.z00)) - $signed(V_W'(q_head.z01));
      ld_v[2] = $signed(V_W'(Z_SPACING));
    end else if (pass_r == P_A) begin
      ld_v[0] = $signed(V_W'(quad_r.z01)) - $signed(V_W'(quad_r.z11));
      ld_v[1] = $signed(V_W'(quad_r.z10)) - $signed(V_W'(quad_r.z11));
      ld_v[2] = $signed(V_W'(Z_SPACING));
    end else begin
      ld_v[0] = V_W'(na_r[0]) + V_W'(nb_r[0]);
      ld_v[1] = V_W'(na_r[1]) + V_W'(nb_r[1]);
      ld_v[2] = V_W'(na_r[2]) + V_W'(nb_r[2]);
    end
  end

  always_comb begin
    m_max = mag_r[0];
    if (mag_r[1] > m_max) m_max = mag_r[1];
    if (mag_r[2] > m_max) m_max = mag_r[2];
  end

  assign scan_done  = (m_max == '0) || m_max[MAG_W-1];
  assign scan_small = (m_max < (MAG_W'(1) << (NORM_TOP - 4)));

  assign rt_start = (st_r == B_RTGO);
  assign rt_x     = (pass_r == P_DOT) ? SUM_W'(tq_r) : acc_r;
  assign dv_start = (st_r == B_DVGO) && (pass_r != P_DOT);
  assign dv_num   = {mag_r[idx_r], FRAC_BITS'(0)};
  assign dv_den   = len_r;
  assign tq_prod  = (2*TM_W+33)'(tsq_r) * (2*TM_W+33)'(RECIP_3);

  always_comb begin
    if (len_r == '0) q_sat = '0;
    else if (dv_quot > NUM_W'(ONE_Q)) q_sat = ONE_Q;
    else q_sat = dv_quot[UNIT_W-1:0];
    comp = sgn_r[idx_r] ? -$signed({1'b0, q_sat}) : $signed({1'b0, q_sat});
  end

  assign t_sum     = (N_W+2)'(n_r[0]) - (N_W+2)'(n_r[1]) + (N_W+2)'(n_r[2]);
  assign mix_sum   = (UNIT_W+2)'(ONE_Q) + (UNIT_W+2)'({dm_r, 1'b0}) + (UNIT_W+2)'(dm_r);
  assign prod_full = (2*UNIT_W)'(ONE_Q - mix_r) * (2*UNIT_W)'(dm_r);
  assign f_sum     = tneg_r ? $signed((UNIT_W+2)'(mix_r)) - $signed((UNIT_W+2)'(prod_r))
                            : $signed((UNIT_W+2)'(mix_r)) + $signed((UNIT_W+2)'(prod_r));

  assign q_pop     = (st_r == B_IDLE) && !q_empty;
  assign out_valid = (st_r == B_OUT);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      B_IDLE: if (!q_empty) st_nxt = B_SCAN;
      B_SCAN: if (scan_done) st_nxt = B_SQ;
      B_SQ:   st_nxt = B_ACC;
      B_ACC:  st_nxt = (idx_r == LAST_IDX) ? B_RTGO : B_SQ;
      B_RTGO: st_nxt = B_RTW;
      B_RTW:  if (rt_done) st_nxt = (pass_r == P_DOT) ? B_MIX : B_DVGO;
      B_DVGO: st_nxt = (pass_r == P_DOT) ? B_RTGO : B_DVW;
      B_DVW: begin
        if (dv_done) st_nxt = (idx_r == LAST_IDX) ? B_NEXT : B_DVGO;
      end
      B_NEXT: st_nxt = (pass_r == P_S) ? B_DOT : B_SCAN;
      B_DOT:  st_nxt = B_TSQ;
      B_TSQ:  st_nxt = B_DVGO;
      B_MIX:  st_nxt = B_PROD;
      B_PROD: st_nxt = B_F;
      B_F:    st_nxt = B_CHAN;
      B_CHAN: st_nxt = B_OUT;
      B_OUT:  if (!out_stall) st_nxt = B_IDLE;
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= B_IDLE;
    else st_r <= st_nxt;
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      B_IDLE: begin
        if (!q_empty) begin
          quad_r <= q_head;
          pass_r <= P_A;
          for (int i = 0; i < 3; i++) begin
            sgn_r[i] <= ld_v[i][V_W-1];
            mag_r[i] <= MAG_W'(ld_v[i][V_W-1] ? -ld_v[i] : ld_v[i]);
          end
        end
      end
      B_SCAN: begin
        if (scan_done) begin
          idx_r <= '0;
          acc_r <= '0;
        end else begin
          for (int i = 0; i < 3; i++) begin
            mag_r[i] <= scan_small ? (mag_r[i] << 4) : (mag_r[i] << 1);
          end
        end
      end
      B_SQ:  sq_r <= mag_r[idx_r] * mag_r[idx_r];
      B_ACC: begin
        acc_r <= acc_r + SUM_W'(sq_r);
        if (idx_r != LAST_IDX) idx_r <= idx_r + 1'b1;
      end
      B_RTW: begin
        if (rt_done) begin
          if (pass_r == P_DOT) begin
            dm_r <= (rt_root > ROOT_W'(ONE_Q)) ? ONE_Q : rt_root[UNIT_W-1:0];
          end else begin
            len_r <= rt_root;
            idx_r <= '0;
          end
        end
      end
      B_DVGO: begin
        if (pass_r == P_DOT) tq_r <= tq_prod[33 +: 2*TM_W];
      end
      B_DVW: begin
        if (dv_done) begin
          unique case (pass_r)
            P_A:     na_r[idx_r] <= comp;
            P_B:     nb_r[idx_r] <= comp;
            default: n_r[idx_r]  <= comp;
          endcase
          if (idx_r != LAST_IDX) idx_r <= idx_r + 1'b1;
        end
      end
      B_NEXT: begin
        if (pass_r != P_S) begin
          pass_r <= (pass_r == P_A) ? P_B : P_S;
          for (int i = 0; i < 3; i++) begin
            sgn_r[i] <= ld_v[i][V_W-1];
            mag_r[i] <= MAG_W'(ld_v[i][V_W-1] ? -ld_v[i] : ld_v[i]);
          end
        end
      end
      B_DOT: begin
        tneg_r <= t_sum[N_W+1];
        tm_r   <= TM_W'(t_sum[N_W+1] ? -t_sum : t_sum);
      end
      B_TSQ: begin
        tsq_r  <= tm_r * tm_r;
        pass_r <= P_DOT;
      end
      B_MIX:  mix_r  <= mix_sum[UNIT_W+1:2];
      B_PROD: prod_r <= prod_full[FRAC_BITS +: UNIT_W];
      B_F:    f_r    <= f_sum[UNIT_W+1] ? '0 : f_sum[UNIT_W-1:0];
      B_CHAN: begin
        if (relief_mode) begin
          red_r   <= shade_chan(quad_r.base[3*CHAN_W-1 -: CHAN_W], f_r);
          green_r <= shade_chan(quad_r.base[2*CHAN_W-1 -: CHAN_W], f_r);
          blue_r  <= shade_chan(quad_r.base[CHAN_W-1:0], f_r);
        end else begin
          red_r   <= norm_chan(N_W'(n_r[0]) + N_W'(ONE_Q));
          green_r <= norm_chan(N_W'(ONE_Q) - N_W'(n_r[1]));
          blue_r  <= norm_chan(N_W'(n_r[2]) + N_W'(ONE_Q));
        end
      end
      default: ;
    endcase
  end

  assign out_pixel_red   = red_r;
  assign out_pixel_green = green_r;
  assign out_pixel_blue  = blue_r;
  assign out_pixel_row   = quad_r.row;
  assign out_pixel_col   = quad_r.col;
  assign out_last_pixel  = quad_r.last;

endmodule

@@ tb/dhnm_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhnm_checker
// Watches the sample, pixel and configuration ports of the hillshade kernel,
// predicts every pixel from the accepted samples and compares field by field.
// ----------------------------------------------------------------------------
module dhnm_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_wr_data,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [dhnm_pkg::HEIGHT_W-1:0] in_height,
  input  logic [dhnm_pkg::CHAN_W-1:0]   in_base_red,
  input  logic [dhnm_pkg::CHAN_W-1:0]   in_base_green,
  input  logic [dhnm_pkg::CHAN_W-1:0]   in_base_blue,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [dhnm_pkg::CHAN_W-1:0]   out_pixel_red,
  input  logic [dhnm_pkg::CHAN_W-1:0]   out_pixel_green,
  input  logic [dhnm_pkg::CHAN_W-1:0]   out_pixel_blue,
  input  logic [dhnm_pkg::COORD_W-1:0]  out_pixel_row,
  input  logic [dhnm_pkg::COORD_W-1:0]  out_pixel_col,
  input  logic                          out_last_pixel,
  output int                            errors,
  output int                            pending
);
  import dhnm_pkg::*;

  localparam longint ONE = longint'(1) << FRAC_BITS;

  typedef struct {
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               last;
  } pixel_t;

  pixel_t              pixels_due[$];
  logic [HEIGHT_W-1:0] line_height[GRID_POINTS];
  logic [COLOR_W-1:0]  line_color[GRID_POINTS];
  logic [SAMPLE_W-1:0] left_s, upleft_s;
  int                  row_pos, col_pos;
  logic                relief;

  function automatic longint isqrt(longint x);
    longint r, b;
    r = 0;
    b = longint'(1) << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint absv(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic void unit_vec(input longint v[3], output longint n[3]);
    longint a[3];
    longint m, s, len, q;
    int k;
    m = 0; s = 0; k = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = absv(v[i]);
      if (a[i] > m) m = a[i];
    end
    // scale up so the root keeps enough bits; direction is unchanged
    while (m != 0 && m < (longint'(1) << 24) && k < 40) begin
      m = m << 1;
      k++;
    end
    for (int i = 0; i < 3; i++) begin
      a[i] = a[i] << k;
      s += a[i] * a[i];
    end
    len = isqrt(s);
    for (int i = 0; i < 3; i++) begin
      q = (len != 0) ? (a[i] << FRAC_BITS) / len : 0;
      if (q > ONE) q = ONE;
      n[i] = v[i] < 0 ? -q : q;
    end
  endfunction

  function automatic logic [CHAN_W-1:0] shade_chan(longint base, longint f);
    longint c;
    c = (base * f) >> FRAC_BITS;
    return c > 255 ? 8'd255 : c[7:0];
  endfunction

  function automatic logic [CHAN_W-1:0] encode_chan(longint n);
    longint c;
    c = (255 * (ONE + n)) >> (FRAC_BITS + 1);
    return c > 255 ? 8'd255 : c[7:0];
  endfunction

  function automatic pixel_t shade_quad(logic [SAMPLE_W-1:0] upright, longint z11);
    pixel_t p;
    longint z00, z01, z10, t, dm, d, mix, prod, f;
    longint va[3], vb[3], na[3], nb[3], vs[3], n[3];
    longint base;
    z00 = upleft_s[SAMPLE_W-1:COLOR_W];
    z01 = upright[SAMPLE_W-1:COLOR_W];
    z10 = left_s[SAMPLE_W-1:COLOR_W];
    va[0] = z00 - z10; va[1] = z00 - z01; va[2] = Z_SPACING;
    vb[0] = z01 - z11; vb[1] = z10 - z11; vb[2] = Z_SPACING;
    unit_vec(va, na);
    unit_vec(vb, nb);
    for (int i = 0; i < 3; i++) vs[i] = na[i] + nb[i];
    unit_vec(vs, n);
    t  = n[0] - n[1] + n[2];
    dm = isqrt(absv(t) * absv(t) / 3);
    if (dm > ONE) dm = ONE;
    d = t < 0 ? -dm : dm;
    if (relief) begin
      mix  = (ONE + 3 * dm) >> 2;
      prod = ((ONE - mix) * dm) >> FRAC_BITS;
      f    = d < 0 ? mix - prod : mix + prod;
      if (f < 0) f = 0;
      base    = upleft_s[COLOR_W-1:0];
      p.red   = shade_chan((base >> 16) & 255, f);
      p.green = shade_chan((base >> 8) & 255, f);
      p.blue  = shade_chan(base & 255, f);
    end else begin
      p.red   = encode_chan(n[0]);
      p.green = encode_chan(-n[1]);
      p.blue  = encode_chan(n[2]);
    end
    p.row  = COORD_W'(GRID_POINTS - 1 - row_pos);
    p.col  = COORD_W'(col_pos - 1);
    p.last = (row_pos == GRID_POINTS - 1) && (col_pos == GRID_POINTS - 1);
    return p;
  endfunction

  always @(posedge clk) begin
    pixel_t              exp_p;
    logic [SAMPLE_W-1:0] upright, cur;
    if (!rst_n) begin
      errors   <= 0;
      pending  <= 0;
      pixels_due.delete();
      left_s   = '0;
      upleft_s = '0;
      row_pos  = 0;
      col_pos  = 0;
      relief   = 1'b1;
    end else begin
      if (cfg_wr_en) relief = cfg_wr_data;
      if (in_valid && !in_stall) begin
        cur     = {in_height, in_base_red, in_base_green, in_base_blue};
        upright = (row_pos == 0) ? '0 : {line_height[col_pos], line_color[col_pos]};
        if (row_pos >= 1 && col_pos >= 1) pixels_due.push_back(shade_quad(upright, in_height));
        upleft_s             = upright;
        line_height[col_pos] = in_height;
        line_color[col_pos]  = cur[COLOR_W-1:0];
        left_s               = cur;
        if (col_pos + 1 >= GRID_POINTS) begin
          col_pos = 0;
          row_pos = (row_pos + 1 >= GRID_POINTS) ? 0 : row_pos + 1;
        end else begin
          col_pos++;
        end
      end
      if (out_valid && !out_stall) begin
        if (pixels_due.size() == 0) begin
          $display("%0t: unexpected pixel row %0d col %0d", $time, out_pixel_row, out_pixel_col);
          errors <= errors + 1;
        end else begin
          exp_p = pixels_due.pop_front();
          if (out_pixel_red !== exp_p.red || out_pixel_green !== exp_p.green ||
              out_pixel_blue !== exp_p.blue || out_pixel_row !== exp_p.row ||
              out_pixel_col !== exp_p.col || out_last_pixel !== exp_p.last) begin
            $display("%0t: pixel mismatch exp rgb %0d/%0d/%0d row %0d col %0d last %0b",
                     $time, exp_p.red, exp_p.green, exp_p.blue, exp_p.row, exp_p.col,
                     exp_p.last);
            $display("%0t:                got rgb %0d/%0d/%0d row %0d col %0d last %0b",
                     $time, out_pixel_red, out_pixel_green, out_pixel_blue, out_pixel_row,
                     out_pixel_col, out_last_pixel);
            errors <= errors + 1;
          end
        end
      end
      pending <= pixels_due.size();
    end
  end
endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams raster elevation samples through the hillshade kernel in both
// output modes, with random idling, a long output hold and drains between
// mode changes; the checker predicts and compares every pixel.
// ----------------------------------------------------------------------------
module testbench;
  import dhnm_pkg::*;

  localparam int SETTLE  = 800;
  localparam int HANG    = 20000;  // cycles with no transfer before giving up
  localparam int HOLD    = 3000;

  logic                clk, rst_n;
  logic                cfg_wr_en, cfg_wr_data;
  logic                in_valid, in_stall;
  logic [HEIGHT_W-1:0] in_height;
  logic [CHAN_W-1:0]   in_base_red, in_base_green, in_base_blue;
  logic                out_valid, out_stall;
  logic [CHAN_W-1:0]   out_pixel_red, out_pixel_green, out_pixel_blue;
  logic [COORD_W-1:0]  out_pixel_row, out_pixel_col;
  logic                out_last_pixel;
  int                  errors, pending;
  logic                quiet, hold_req;
  logic [HEIGHT_W-1:0] last_h;
  int                  stuck;

  dem_hillshade_normal_map u_top (.*);

  dhnm_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver side: random stall, quiet stretches, one long hold
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD - 1) @(negedge clk);
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 18);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      stuck <= 0;
    end else begin
      stuck <= stuck + 1;
      if (stuck > HANG) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic send(logic [HEIGHT_W-1:0] h, logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                      logic [CHAN_W-1:0] b);
    while (!quiet && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_height     <= h;
    in_base_red   <= r;
    in_base_green <= g;
    in_base_blue  <= b;
    last_h         = h;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  function automatic logic [CHAN_W-1:0] rand_chan();
    int k;
    k = $urandom_range(9);
    return k == 0 ? 8'd0 : k == 1 ? 8'd255 : CHAN_W'($urandom);
  endfunction

  task automatic send_random(int count);
    logic [HEIGHT_W-1:0] h;
    int                  k;
    repeat (count) begin
      k = $urandom_range(99);
      if (k < 70)      h = last_h + HEIGHT_W'($urandom_range(400)) - HEIGHT_W'(200);
      else if (k < 85) h = HEIGHT_W'($urandom);
      else             h = $urandom_range(1) ? '1 : '0;
      send(h, rand_chan(), rand_chan(), rand_chan());
    end
  endtask

  // edge cases: flat ground, full-scale cliffs each way, colour extremes
  task automatic send_corners();
    for (int i = 0; i < 24; i++) begin
      case (i / 6)
        0:       send(16'd1000, 8'hff, 8'hff, 8'hff);
        1:       send(i[0] ? 16'hffff : 16'h0000, 8'hff, 8'h00, 8'hff);
        2:       send(i[1] ? 16'hffff : 16'h0000, 8'h00, 8'hff, 8'h00);
        default: send(16'(i * 11000), 8'hff, 8'h80, 8'h01);
      endcase
    end
  endtask

  task automatic drain_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_mode(logic m);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = 1'b0;
    in_valid      = 1'b0;
    in_height     = '0;
    in_base_red   = '0;
    in_base_green = '0;
    in_base_blue  = '0;
    quiet         = 1'b0;
    hold_req      = 1'b0;
    last_h        = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // grid row 0 produces nothing, row 1 onward one pixel per sample past column 0
    send_corners();
    send_random(GRID_POINTS - 24);
    send_corners();
    send_random(40);
    drain_idle();

    set_mode(1'b0);
    send_corners();
    quiet = 1'b1;
    send_random(80);
    quiet = 1'b0;
    drain_idle();

    set_mode(1'b1);
    hold_req <= 1'b1;
    @(negedge clk);
    hold_req <= 1'b0;
    send_random(100);
    drain_idle();

    set_mode(1'b0);
    send_random(60);
    drain_idle();

    set_mode(1'b1);
    send_random(60);
    drain_idle();

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
